// ===== sv/sort_by_parity_position_popcount_top_defines.svh =====
// Assertion macros used by the sorter's top-level RTL file.
`ifndef SORT_BY_PARITY_POSITION_POPCOUNT_TOP_DEFINES_SVH
`define SORT_BY_PARITY_POSITION_POPCOUNT_TOP_DEFINES_SVH

// The condition must never be true at a clock edge outside reset.
`define SBPP_ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define SBPP_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== sv/sbpp_pkg.sv =====
// Types, constants and key functions shared by the sorter's modules.
`default_nettype none

package sbpp_pkg;

   localparam int WORD_W = 32;
   localparam int HALF_W = WORD_W / 2;
   localparam int COUNT_W = $clog2(HALF_W + 1);

   // Sort key: even-position ones are primary, odd-position ones secondary.
   // Comparing the packed struct as one vector gives the right order.
   typedef struct packed {
      logic [COUNT_W-1:0] even_ones;
      logic [COUNT_W-1:0] odd_ones;
   } key_type;

   // One classified input item.
   typedef struct packed {
      logic signed [WORD_W-1:0] value;
      logic                     last;
      key_type                  key;
   } item_type;

   // One stored element with its key.
   typedef struct packed {
      key_type                  key;
      logic signed [WORD_W-1:0] value;
   } entry_type;

   // One result item.
   typedef struct packed {
      logic signed [WORD_W-1:0] sorted_value;
      logic                     end_of_run;
      logic                     dropped;
   } rsp_type;

   typedef enum logic [1:0] {
      BACK_COLLECT,
      BACK_SORT,
      BACK_DRAIN,
      BACK_EMIT
   } back_state_type;

   // Ones in a nibble.
   function automatic logic [2:0] nibble_ones(input logic [3:0] nib);
      nibble_ones = 3'(nib[0]) + 3'(nib[1]) + 3'(nib[2]) + 3'(nib[3]);
   endfunction

   // Ones in a half word, summed nibble by nibble.
   function automatic logic [COUNT_W-1:0] half_ones(input logic [HALF_W-1:0] v);
      logic [COUNT_W-1:0] total;
      total = '0;
      for (int k = 0; k < HALF_W / 4; k++) begin
         total = total + COUNT_W'(nibble_ones(v[4*k +: 4]));
      end
      half_ones = total;
   endfunction

   // Key of a word: split it into its even and odd bit positions.
   function automatic key_type word_key(input logic [WORD_W-1:0] w);
      logic [HALF_W-1:0] even_bits;
      logic [HALF_W-1:0] odd_bits;
      key_type           k;
      for (int b = 0; b < HALF_W; b++) begin
         even_bits[b] = w[2*b];
         odd_bits[b]  = w[2*b + 1];
      end
      k.even_ones = half_ones(even_bits);
      k.odd_ones  = half_ones(odd_bits);
      word_key = k;
   endfunction

endpackage

`default_nettype wire

// ===== sv/sbpp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sbpp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/sbpp_fifo.sv =====
// Small register queue with push/full and pop/empty sides.
`default_nettype none

module sbpp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   output logic                  full,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             pop,
   output logic                  empty,
   output logic      [WIDTH-1:0] rd_data
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

// ===== sv/sbpp_front.sv =====
// Front end: accepts input items and attaches their sort key.
`default_nettype none

module sbpp_front (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_push,
   output logic                          req_full,
   input  wire logic signed [31:0]       req_value,
   input  wire logic                     req_last,
   output logic                          q_push,
   input  wire logic                     q_full,
   output sbpp_pkg::item_type            q_data
);

   import sbpp_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     accept;

   assign req_full = valid_ff && q_full;
   assign accept   = req_push && !req_full;
   assign q_push   = valid_ff;
   assign q_data   = item_ff;

   // Classify the incoming word and hold it until the queue takes it.
   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (accept) begin
         valid_in      = 1'b1;
         item_in.value = req_value;
         item_in.last  = req_last;
         item_in.key   = word_key(req_value);
      end else if (valid_ff && !q_full) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

`default_nettype wire

// ===== sv/sbpp_back.sv =====
// Back end: stores a run, exchange-sorts it in RAM and emits the results.
`default_nettype none

module sbpp_back #(
   parameter int MAX_ITEMS = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_empty,
   output logic                    q_pop,
   input  wire sbpp_pkg::item_type q_data,
   input  wire logic               out_full,
   output logic                    out_push,
   output sbpp_pkg::rsp_type       out_data
);

   import sbpp_pkg::*;

   localparam int AW = $clog2(MAX_ITEMS);
   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam int EW = $bits(entry_type);

   back_state_type state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           ovf_ff, ovf_in;
   logic           drop_ff, drop_in;
   logic [CW-1:0]  n_ff, n_in;
   logic [AW-1:0]  i_ff, i_in;
   logic [CW-1:0]  rd_ff, rd_in;
   logic           rd_valid_ff, rd_valid_in;
   logic           rd_first_ff, rd_first_in;
   logic [AW-1:0]  ret_addr_ff, ret_addr_in;
   entry_type      cur_ff, cur_in;

   logic           ram_wr_en;
   logic [AW-1:0]  ram_wr_addr;
   entry_type      ram_wr_data;
   logic           ram_rd_en;
   logic [EW-1:0]  ram_rd_bits;
   entry_type      ram_rd_data;
   entry_type      new_entry;
   logic           room;
   logic           store_word;
   logic           swap;
   logic           last_pass;

   assign ram_rd_data     = entry_type'(ram_rd_bits);
   assign new_entry.key   = q_data.key;
   assign new_entry.value = q_data.value;
   assign room            = (count_ff < CW'(MAX_ITEMS));
   assign store_word      = q_pop && room;
   assign last_pass       = (CW'(i_ff) + CW'(1) == n_ff);
   // A later element with a larger key displaces the held one.
   assign swap = rd_valid_ff && !rd_first_ff && (cur_ff.key < ram_rd_data.key);

   sbpp_ram #(
      .WIDTH(EW),
      .DEPTH(MAX_ITEMS)
   ) u_store (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(rd_ff[AW-1:0]),
      .rd_data(ram_rd_bits)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_COLLECT: begin
            if (!q_empty && q_data.last) begin
               state_in = BACK_SORT;
            end
         end
         BACK_SORT: begin
            if (rd_ff + CW'(1) == n_ff) begin
               state_in = BACK_DRAIN;
            end
         end
         BACK_DRAIN: begin
            state_in = BACK_EMIT;
         end
         BACK_EMIT: begin
            if (!out_full) begin
               state_in = last_pass ? BACK_COLLECT : BACK_SORT;
            end
         end
         default: begin
            state_in = BACK_COLLECT;
         end
      endcase
   end

   // State outputs.
   always_comb begin
      q_pop     = 1'b0;
      ram_rd_en = 1'b0;
      out_push  = 1'b0;
      case (state_ff)
         BACK_COLLECT: begin
            q_pop = !q_empty;
         end
         BACK_SORT: begin
            ram_rd_en = 1'b1;
         end
         BACK_DRAIN: begin
            ram_rd_en = 1'b0;
         end
         BACK_EMIT: begin
            out_push = !out_full;
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   // RAM write: either a new element or the displaced one going back.
   always_comb begin
      ram_wr_en   = store_word || swap;
      ram_wr_addr = swap ? ret_addr_ff : count_ff[AW-1:0];
      ram_wr_data = swap ? cur_ff : new_entry;
   end

   // Result item for the current pass.
   always_comb begin
      out_data.sorted_value = cur_ff.value;
      out_data.end_of_run   = last_pass;
      out_data.dropped      = drop_ff;
   end

   // Counters, pass indexes and the held element.
   always_comb begin
      count_in    = count_ff;
      ovf_in      = ovf_ff;
      drop_in     = drop_ff;
      n_in        = n_ff;
      i_in        = i_ff;
      rd_in       = rd_ff;
      rd_valid_in = 1'b0;
      rd_first_in = 1'b0;
      ret_addr_in = ret_addr_ff;
      cur_in      = cur_ff;

      // Collect: store while there is room, otherwise note the loss.
      if (q_pop) begin
         if (room) begin
            count_in = count_ff + CW'(1);
         end else begin
            ovf_in = 1'b1;
         end
         if (q_data.last) begin
            n_in     = room ? count_ff + CW'(1) : count_ff;
            drop_in  = ovf_ff || !room;
            count_in = '0;
            ovf_in   = 1'b0;
            i_in     = '0;
            rd_in    = '0;
         end
      end

      // Sort pass: read element i first, then every later element.
      if (state_ff == BACK_SORT) begin
         rd_in       = rd_ff + CW'(1);
         rd_valid_in = 1'b1;
         rd_first_in = (rd_ff == CW'(i_ff));
         ret_addr_in = rd_ff[AW-1:0];
      end

      // Returned read data: load the held element or take the larger one.
      if (rd_valid_ff && (rd_first_ff || swap)) begin
         cur_in = ram_rd_data;
      end

      // Emit: the held element is final for position i.
      if (out_push && !last_pass) begin
         i_in  = i_ff + AW'(1);
         rd_in = CW'(i_ff) + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= BACK_COLLECT;
         count_ff    <= '0;
         ovf_ff      <= 1'b0;
         drop_ff     <= 1'b0;
         n_ff        <= '0;
         i_ff        <= '0;
         rd_ff       <= '0;
         rd_valid_ff <= 1'b0;
         rd_first_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         ovf_ff      <= ovf_in;
         drop_ff     <= drop_in;
         n_ff        <= n_in;
         i_ff        <= i_in;
         rd_ff       <= rd_in;
         rd_valid_ff <= rd_valid_in;
         rd_first_ff <= rd_first_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_addr_ff <= ret_addr_in;
      cur_ff      <= cur_in;
   end

endmodule

`default_nettype wire

// ===== sv/sort_by_parity_position_popcount_top.sv =====
// Top level of the custom-key descending exchange sorter.
//
//   Channel   Direction  Handshake      Fields
//   req       in         push / full    value, last
//   rsp       out        pop / empty    sorted_value, end_of_run, dropped
//
// A run of N words loads at one word per cycle while the back end collects.
// Sort pass i makes (N - i) RAM reads, one at a time through the single
// read port of the element RAM, then a drain step and an emit step.
// Reset is synchronous and needs no clearing pass. A full result queue
// stalls only the emit step; the input queue fills while a run is sorted
// and then raises full.
`default_nettype none
`include "sort_by_parity_position_popcount_top_defines.svh"

module sort_by_parity_position_popcount_top #(
   parameter int MAX_ITEMS = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   output logic                    req_full,
   input  wire logic signed [31:0] req_value,
   input  wire logic               req_last,
   output logic                    rsp_empty,
   input  wire logic               rsp_pop,
   output logic signed [31:0]      rsp_sorted_value,
   output logic                    rsp_end_of_run,
   output logic                    rsp_dropped
);

   import sbpp_pkg::*;

   localparam int QUEUE_DEPTH = 4;
   localparam int OUT_DEPTH   = 2;

   logic     q_push, q_full, q_pop, q_empty;
   item_type q_wr_data;
   logic [$bits(item_type)-1:0] q_rd_bits;
   logic     out_push, out_full;
   rsp_type  out_wr_data;
   logic [$bits(rsp_type)-1:0]  out_rd_bits;
   rsp_type  out_rd_data;

   sbpp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_value(req_value),
      .req_last (req_last),
      .q_push   (q_push),
      .q_full   (q_full),
      .q_data   (q_wr_data)
   );

   // Queue between the front and the back.
   sbpp_fifo #(
      .WIDTH($bits(item_type)),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .full   (q_full),
      .wr_data(q_wr_data),
      .pop    (q_pop),
      .empty  (q_empty),
      .rd_data(q_rd_bits)
   );

   sbpp_back #(
      .MAX_ITEMS(MAX_ITEMS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_pop   (q_pop),
      .q_data  (item_type'(q_rd_bits)),
      .out_full(out_full),
      .out_push(out_push),
      .out_data(out_wr_data)
   );

   // Result queue decouples emitting from the consumer.
   sbpp_fifo #(
      .WIDTH($bits(rsp_type)),
      .DEPTH(OUT_DEPTH)
   ) u_out (
      .clock  (clock),
      .reset  (reset),
      .push   (out_push),
      .full   (out_full),
      .wr_data(out_wr_data),
      .pop    (rsp_pop),
      .empty  (rsp_empty),
      .rd_data(out_rd_bits)
   );

   assign out_rd_data      = rsp_type'(out_rd_bits);
   assign rsp_sorted_value = out_rd_data.sorted_value;
   assign rsp_end_of_run   = out_rd_data.end_of_run;
   assign rsp_dropped      = out_rd_data.dropped;

   // Internal handshake checks.
   `SBPP_ASSERT_NEVER(a_out_no_overrun, out_push && out_full, "result queue overrun")
   `SBPP_ASSERT_NEVER(a_queue_no_underrun, q_pop && q_empty, "item queue underrun")
   `SBPP_ASSERT_IMPLY(a_full_means_queue_full, req_full, q_full, "front stalled needlessly")

endmodule

`default_nettype wire

// ===== sim/tb_sort_by_parity_position_popcount_top.sv =====
// Self-checking testbench for the parity-position popcount exchange sorter.
`timescale 1ns / 1ps

// Scoreboard: gathers the words of the open run and predicts its sorted output.
class sorted_run_board;
   int unsigned       capacity;
   logic [31:0]       held_words[$];
   bit                words_lost;
   sbpp_pkg::rsp_type sorted_due[$];
   int unsigned       errors;

   function new(int unsigned cap);
      capacity   = cap;
      words_lost = 0;
      errors     = 0;
   endfunction

   // Even-position ones rank first, odd-position ones break ties.
   function int unsigned parity_rank(logic [31:0] w);
      return $countones(w & 32'h5555_5555) * 64 + $countones(w & 32'hAAAA_AAAA);
   endfunction

   task report(string msg);
      $display("mismatch at %0t ns: %s", $time, msg);
      errors++;
   endtask

   // Store or drop an accepted item; a last item sorts the run into results.
   function void note_item(logic [31:0] word, logic last);
      logic [31:0]       swap_word;
      sbpp_pkg::rsp_type due;
      int                n;
      if (held_words.size() < capacity) begin
         held_words.push_back(word);
      end else begin
         words_lost = 1;
      end
      if (!last) begin
         return;
      end
      n = held_words.size();
      // Plain exchange sort, so that equal keys land exactly where the block puts them.
      for (int i = 0; i < n; i++) begin
         for (int j = i + 1; j < n; j++) begin
            if (parity_rank(held_words[i]) < parity_rank(held_words[j])) begin
               swap_word     = held_words[i];
               held_words[i] = held_words[j];
               held_words[j] = swap_word;
            end
         end
      end
      for (int k = 0; k < n; k++) begin
         due.sorted_value = held_words[k];
         due.end_of_run   = (k == n - 1);
         due.dropped      = words_lost;
         sorted_due.push_back(due);
      end
      held_words.delete();
      words_lost = 0;
   endfunction

   function int pending();
      return sorted_due.size();
   endfunction

   // Compare one accepted result with the oldest prediction.
   task check_result(logic [31:0] value, logic eor, logic drop);
      sbpp_pkg::rsp_type due;
      if (sorted_due.size() == 0) begin
         report($sformatf("result %h arrived with nothing expected", value));
         return;
      end
      due = sorted_due.pop_front();
      if (value !== due.sorted_value) begin
         report($sformatf("sorted_value %h, expected %h", value, due.sorted_value));
      end
      if (eor !== due.end_of_run) begin
         report($sformatf("end_of_run %b, expected %b (value %h)", eor, due.end_of_run,
                          due.sorted_value));
      end
      if (drop !== due.dropped) begin
         report($sformatf("dropped %b, expected %b (value %h)", drop, due.dropped,
                          due.sorted_value));
      end
   endtask
endclass

module tb_sort_by_parity_position_popcount_top;

   localparam int MAX_ITEMS    = 64;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 100;
   localparam int RANDOM_ITEMS = 110;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_push  = 1'b0;
   logic signed [31:0] req_value = '0;
   logic               req_last  = 1'b0;
   logic               rsp_pop   = 1'b0;
   logic               req_full;
   logic               rsp_empty;
   logic signed [31:0] rsp_sorted_value;
   logic               rsp_end_of_run;
   logic               rsp_dropped;

   sorted_run_board board;
   bit              no_idle      = 0;
   int              hold_req     = 0;
   bit              holding      = 0;
   int              random_count = 0;

   sort_by_parity_position_popcount_top #(
      .MAX_ITEMS(MAX_ITEMS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_value       (req_value),
      .req_last        (req_last),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_sorted_value(rsp_sorted_value),
      .rsp_end_of_run  (rsp_end_of_run),
      .rsp_dropped     (rsp_dropped)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one; none while idling is off.
   function int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // Random words: full-range, sparse ones for many equal keys, extremes, masked.
   function logic [31:0] rand_word();
      int unsigned a;
      int unsigned b;
      a = $urandom_range(0, 31);
      b = $urandom_range(0, 31);
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return (32'h1 << a) | (32'h1 << b);
         2: begin
            case ($urandom_range(0, 5))
               0: return 32'h0000_0000;
               1: return 32'hFFFF_FFFF;
               2: return 32'h8000_0000;
               3: return 32'h7FFF_FFFF;
               4: return 32'h5555_5555;
               default: return 32'hAAAA_AAAA;
            endcase
         end
         3: return $urandom & 32'h5555_5555;
         default: return $urandom & 32'hAAAA_AAAA;
      endcase
   endfunction

   function int unsigned pick_run_len();
      if ($urandom_range(0, 99) < 80) begin
         return $urandom_range(1, 8);
      end
      return $urandom_range(9, 20);
   endfunction

   // Offer one item until the block takes it, then idle for a random gap.
   task send_item(logic [31:0] word, logic last);
      int unsigned gap;
      req_push  <= 1'b1;
      req_value <= word;
      req_last  <= last;
      @(posedge clock);
      while (req_full) begin
         @(posedge clock);
      end
      board.note_item(word, last);
      gap = pick_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task send_random_run(int unsigned len);
      for (int unsigned k = 0; k < len; k++) begin
         send_item(rand_word(), k == len - 1);
         random_count++;
      end
   endtask

   // Sender pause: wait until every predicted result has been taken.
   task settle();
      req_push <= 1'b0;
      while (board.pending() != 0) begin
         @(posedge clock);
      end
   endtask

   // Stimulus.
   initial begin
      int unsigned len;
      board = new(MAX_ITEMS);
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Single-word runs at both ends of the range.
      send_item(32'h0000_0000, 1'b1);
      send_item(32'hFFFF_FFFF, 1'b1);
      // Extremes in one run, sent back to back.
      no_idle = 1;
      send_item(32'h7FFF_FFFF, 1'b0);
      send_item(32'h8000_0000, 1'b0);
      send_item(32'h5555_5555, 1'b0);
      send_item(32'hAAAA_AAAA, 1'b0);
      send_item(32'h0000_0000, 1'b0);
      send_item(32'hFFFF_FFFF, 1'b1);
      no_idle = 0;
      // Equal keys interleaved, so the exchange order among ties shows.
      send_item(32'h0000_0001, 1'b0);
      send_item(32'h0000_0002, 1'b0);
      send_item(32'h0000_0004, 1'b0);
      send_item(32'h0000_0008, 1'b0);
      send_item(32'h0000_0010, 1'b0);
      send_item(32'h0000_0020, 1'b0);
      send_item(32'h0000_0003, 1'b1);
      // The sign bit counts as an odd position.
      send_item(32'h8000_0000, 1'b0);
      send_item(32'h0000_0002, 1'b1);
      settle();

      // Random short runs with idling on both sides.
      while (random_count < 20) begin
         send_random_run(pick_run_len());
      end

      // Receiver holds off while the sender keeps offering, so full rises.
      no_idle  = 1;
      hold_req = HOLD_CYCLES;
      do begin
         send_random_run(pick_run_len());
      end while ((holding || hold_req != 0) && random_count < 50);
      no_idle = 0;
      settle();

      // Overflow: the store fills, later words and the last one are dropped.
      len = MAX_ITEMS + $urandom_range(1, 3);
      send_random_run(len);

      while (random_count < RANDOM_ITEMS) begin
         send_random_run(pick_run_len());
      end
      req_push <= 1'b0;

      while (board.pending() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Receiver: check each accepted result, then decide the next pop.
   initial begin
      int unsigned gap_left;
      int unsigned hold_left;
      gap_left  = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            board.check_result(rsp_sorted_value, rsp_end_of_run, rsp_dropped);
         end
         if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
         end
         holding = (hold_left != 0);
         if (hold_left != 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (gap_left != 0) begin
            gap_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
            if ($urandom_range(0, 3) == 0) begin
               gap_left = pick_gap();
            end
         end
      end
   end

   // Watchdog for a hung block.
   initial begin
      #400_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+sv
sv/sbpp_pkg.sv
sv/sbpp_ram.sv
sv/sbpp_fifo.sv
sv/sbpp_front.sv
sv/sbpp_back.sv
sv/sort_by_parity_position_popcount_top.sv
sim/tb_sort_by_parity_position_popcount_top.sv
